@@ rtl/nfps_pkg.sv @@
// Shared constants and payload types for the nearest/farthest point swap block.
`default_nettype none

package nfps_pkg;

  localparam int NUM_POINTS = 8;
  localparam int IDX_W      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } point_t;

  typedef struct packed {
    logic        [5:0]  point_index;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               last_point;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/nearest_farthest_point_swap.sv @@
// Top level: point collection, serial distance unit, min/max tracking and emission.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// point     in         point_valid / point_stall  nfps_pkg::point_t  (coord_x, coord_y)
// result    out        result_valid/ result_stall nfps_pkg::result_t (index, x, y, last)
//
// From its transfer, each point passes through the radix-4 shift-add squarer,
// the one-digit-per-cycle square root, an update state and back to idle before
// the next point can transfer. After the last point of a set the points
// leave from the store one per cycle while result_stall is low. Reset (rst,
// synchronous) clears the controller and the trackers; the point store holds
// garbage until a set is written. point_stall stays high while busy or emitting.

module nearest_farthest_point_swap (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              point_valid,
  output logic                   point_stall,
  input  wire nfps_pkg::point_t  point_data,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output nfps_pkg::result_t      result_data
);

  localparam int IW = nfps_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [IW-1:0] LAST_IDX = IW'(nfps_pkg::NUM_POINTS - 1);

  logic [2:0]    state;
  logic [3:0]    cnt;
  logic [IW-1:0] load_count;
  logic [IW-1:0] emit_idx;
  logic [15:0]   least_distance;
  logic [15:0]   greatest_distance;
  logic [IW-1:0] nearest_index;
  logic [IW-1:0] farthest_index;

  // squarer and root datapath
  logic [31:0] axs, ays;
  logic [15:0] mx, my;
  logic [31:0] sum, sum_next;
  logic [31:0] rem, rem_next;
  logic [31:0] root, root_next;
  logic [31:0] rbit;
  logic [31:0] trial;

  logic [15:0] ax, ay;
  logic        point_xfer;
  logic        emit_load;
  logic [IW-1:0] rd_addr;
  logic        swap_en;
  logic [15:0] distance;

  nfps_pkg::point_t point_store [nfps_pkg::NUM_POINTS];

  assign point_stall = (state != S_IDLE);
  assign point_xfer  = point_valid && !point_stall;
  assign emit_load   = (state == S_EMIT) && (!result_valid || !result_stall);
  assign distance    = root[15:0];

  // Magnitude of a 16-bit two's complement value; -32768 maps to 0x8000.
  assign ax = point_data.coord_x[15] ? 16'(-point_data.coord_x) : point_data.coord_x;
  assign ay = point_data.coord_y[15] ? 16'(-point_data.coord_y) : point_data.coord_y;

  // Two multiplier bits of each square per cycle.
  always_comb begin
    sum_next = sum
             + (mx[0] ? axs : 32'd0) + (mx[1] ? {axs[30:0], 1'b0} : 32'd0)
             + (my[0] ? ays : 32'd0) + (my[1] ? {ays[30:0], 1'b0} : 32'd0);
  end

  // One result bit of the floor square root per cycle.
  always_comb begin
    trial = root + rbit;
    if (rem >= trial) begin
      rem_next  = rem - trial;
      root_next = (root >> 1) + rbit;
    end else begin
      rem_next  = rem;
      root_next = root >> 1;
    end
  end

  // Swap nearest and farthest on the way out by remapping the read address.
  assign swap_en = (nearest_index != farthest_index);
  always_comb begin
    priority if (swap_en && emit_idx == nearest_index) begin
      rd_addr = farthest_index;
    end else if (swap_en && emit_idx == farthest_index) begin
      rd_addr = nearest_index;
    end else begin
      rd_addr = emit_idx;
    end
  end

  // Controller and trackers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      cnt               <= '0;
      load_count        <= '0;
      emit_idx          <= '0;
      least_distance    <= '0;
      greatest_distance <= '0;
      nearest_index     <= '0;
      farthest_index    <= '0;
      result_valid      <= 1'b0;
    end else begin
      // drop the result once its transfer completes, unless a new one loads below
      if (result_valid && !result_stall && !emit_load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (point_xfer) begin
            state <= S_MUL;
            cnt   <= '0;
          end
        end
        S_MUL: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd7) begin
            state <= S_SQRT;
            cnt   <= '0;
          end
        end
        S_SQRT: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (load_count == '0) begin
            least_distance    <= distance;
            greatest_distance <= distance;
            nearest_index     <= '0;
            farthest_index    <= '0;
          end else if (distance < least_distance) begin
            least_distance <= distance;
            nearest_index  <= load_count;
          end else if (distance > greatest_distance) begin
            greatest_distance <= distance;
            farthest_index    <= load_count;
          end
          if (load_count == LAST_IDX) begin
            load_count <= '0;
            emit_idx   <= '0;
            state      <= S_EMIT;
          end else begin
            load_count <= load_count + 1'b1;
            state      <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            result_valid <= 1'b1;
            emit_idx     <= emit_idx + 1'b1;
            if (emit_idx == LAST_IDX) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (point_xfer) begin
      axs  <= {16'd0, ax};
      ays  <= {16'd0, ay};
      mx   <= ax;
      my   <= ay;
      sum  <= '0;
    end else if (state == S_MUL) begin
      axs <= {axs[29:0], 2'b00};
      ays <= {ays[29:0], 2'b00};
      mx  <= {2'b00, mx[15:2]};
      my  <= {2'b00, my[15:2]};
      sum <= sum_next;
    end
    if (state == S_MUL && cnt == 4'd7) begin
      rem  <= sum_next;
      root <= '0;
      rbit <= 32'h4000_0000;
    end else if (state == S_SQRT) begin
      rem  <= rem_next;
      root <= root_next;
      rbit <= {2'b00, rbit[31:2]};
    end
  end

  // Point store: written on transfer, read straight into the result register.
  always_ff @(posedge clk) begin
    if (point_xfer) begin
      point_store[load_count] <= point_data;
    end
    if (emit_load) begin
      result_data.point_index <= 6'(emit_idx);
      result_data.out_x       <= point_store[rd_addr].coord_x;
      result_data.out_y       <= point_store[rd_addr].coord_y;
      result_data.last_point  <= (emit_idx == LAST_IDX);
    end
  end

endmodule

`default_nettype wire

@@ test/nearest_farthest_point_swap_test.sv @@
// Testbench for the nearest/farthest point swap block: directed and random point sets.
`timescale 1ns / 100ps

module nearest_farthest_point_swap_test;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              point_valid  = 1'b0;
  nfps_pkg::point_t  point_data   = '0;
  logic              result_stall = 1'b0;
  logic              point_stall;
  logic              result_valid;
  nfps_pkg::result_t result_data;

  nearest_farthest_point_swap u_top (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_data   (point_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Points waiting to go out, and the emitted points we still expect to see.
  nfps_pkg::point_t  pending_points[$];
  nfps_pkg::result_t awaited_results[$];

  int idle_pct        = 0;  // chance per cycle that the sender holds off
  int stall_pct       = 0;  // chance per cycle that the receiver stalls
  int points_queued   = 0;
  int points_accepted = 0;
  int mismatch_count  = 0;
  logic point_taken   = 1'b0;

  // Our own copy of the block's state: the current set and the running extremes.
  nfps_pkg::point_t held_points [nfps_pkg::NUM_POINTS];
  int               points_loaded = 0;
  logic [15:0]      nearest_dist;
  logic [15:0]      farthest_dist;
  int               nearest_at;
  int               farthest_at;

  // Absolute value of a coordinate; -32768 maps to 32768.
  function automatic logic [31:0] magnitude(input logic signed [15:0] c);
    return c[15] ? (32'h1_0000 - {16'h0, c}) : {16'h0, c};
  endfunction

  // Fold one accepted point into the set; on the last point of a set, swap the
  // nearest and farthest entries and queue every point as an expected result.
  task automatic track_point(input nfps_pkg::point_t p);
    logic [31:0]       mx;
    logic [31:0]       my;
    logic [31:0]       sum_sq;
    logic [15:0]       root;
    logic [15:0]       trial;
    logic [63:0]       trial_sq;
    nfps_pkg::point_t  held;
    nfps_pkg::result_t r;
    mx = magnitude(p.coord_x);
    my = magnitude(p.coord_y);
    sum_sq = mx * mx + my * my;
    // Build the floor root one bit at a time, keeping a bit if its square fits.
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial    = root | (16'd1 << b);
      trial_sq = 64'(trial) * 64'(trial);
      if (trial_sq <= 64'(sum_sq)) root = trial;
    end
    held_points[points_loaded] = p;
    // The first point seeds both extremes; later ones replace only on a strict win.
    if (points_loaded == 0) begin
      nearest_dist  = root;
      farthest_dist = root;
      nearest_at    = 0;
      farthest_at   = 0;
    end else if (root < nearest_dist) begin
      nearest_dist = root;
      nearest_at   = points_loaded;
    end else if (root > farthest_dist) begin
      farthest_dist = root;
      farthest_at   = points_loaded;
    end
    if (points_loaded < nfps_pkg::NUM_POINTS - 1) begin
      points_loaded++;
    end else begin
      if (nearest_at != farthest_at) begin
        held                     = held_points[nearest_at];
        held_points[nearest_at]  = held_points[farthest_at];
        held_points[farthest_at] = held;
      end
      for (int k = 0; k < nfps_pkg::NUM_POINTS; k++) begin
        r.point_index = 6'(k);
        r.out_x       = held_points[k].coord_x;
        r.out_y       = held_points[k].coord_y;
        r.last_point  = (k == nfps_pkg::NUM_POINTS - 1);
        awaited_results.push_back(r);
      end
      points_loaded = 0;
    end
  endtask

  // Drive at the falling edge. Hold a point until its transfer, then pick the
  // next one or go idle; the stall for results is redrawn every cycle.
  always @(negedge clk) begin
    if (rst) begin
      point_valid  <= 1'b0;
      result_stall <= 1'b0;
    end else begin
      if (!point_valid || point_taken) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct) begin
          point_data  <= pending_points.pop_front();
          point_valid <= 1'b1;
        end else begin
          point_valid <= 1'b0;
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Sample at the rising edge: check each result transfer against the oldest
  // expectation, then predict from each point transfer.
  always @(posedge clk) begin : monitor
    nfps_pkg::result_t want;
    if (rst) begin
      point_taken <= 1'b0;
    end else begin
      point_taken <= point_valid && !point_stall;
      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer: point_index %0d, out_x %0d, out_y %0d",
                 result_data.point_index, result_data.out_x, result_data.out_y);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (result_data.point_index !== want.point_index) begin
            $error("point_index: expected %0d, got %0d",
                   want.point_index, result_data.point_index);
            mismatch_count++;
          end
          if (result_data.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, result_data.out_x);
            mismatch_count++;
          end
          if (result_data.out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", want.out_y, result_data.out_y);
            mismatch_count++;
          end
          if (result_data.last_point !== want.last_point) begin
            $error("last_point: expected %0d, got %0d",
                   want.last_point, result_data.last_point);
            mismatch_count++;
          end
        end
      end
      if (point_valid && !point_stall) begin
        track_point(point_data);
        points_accepted++;
      end
    end
  end

  task automatic add_point(input logic signed [15:0] x, input logic signed [15:0] y);
    nfps_pkg::point_t p;
    p.coord_x = x;
    p.coord_y = y;
    pending_points.push_back(p);
    points_queued++;
  endtask

  function automatic logic signed [15:0] corner_coord();
    case ($urandom_range(5))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // Queue whole sets with random content: mostly full-range points, some small
  // ones so distances collide, some corners, and mirrored points to force ties.
  // Now and then a set repeats one point throughout, so no swap happens.
  task automatic queue_random_sets(input int sets);
    nfps_pkg::point_t p;
    int               flavor;
    int               pick;
    for (int s = 0; s < sets; s++) begin
      flavor = $urandom_range(7);
      for (int k = 0; k < nfps_pkg::NUM_POINTS; k++) begin
        pick = $urandom_range(19);
        if (k != 0 && (flavor == 0 || pick < 3)) begin
          if (flavor != 0) p = {p.coord_y, p.coord_x};
        end else if (pick < 11) begin
          p = nfps_pkg::point_t'($urandom);
        end else if (pick < 17) begin
          p.coord_x = 16'($urandom_range(40) - 20);
          p.coord_y = 16'($urandom_range(40) - 20);
        end else begin
          p.coord_x = corner_coord();
          p.coord_y = corner_coord();
        end
        add_point(p.coord_x, p.coord_y);
      end
    end
  endtask

  // Hold off until every queued point has gone through and every set has come
  // back, then step to a rising edge so the next pushes never race the driver.
  task automatic drain_block();
    while (points_accepted != points_queued || awaited_results.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // Extremes: origin seed, corner points, ties on the farthest and on the
    // nearest; nearest at 0 and farthest at 2 get swapped.
    add_point(0, 0);
    add_point(32767, 32767);
    add_point(-32768, -32768);
    add_point(-32768, -32768);
    add_point(-1, 1);
    add_point(32767, -32768);
    add_point(0, 0);
    add_point(1, 0);
    // Every point at distance five: both extremes stay on the first, no swap.
    add_point(3, 4);
    add_point(4, 3);
    add_point(-5, 0);
    add_point(0, 5);
    add_point(-3, -4);
    add_point(5, 0);
    add_point(0, -5);
    add_point(4, -3);
    // Extremes move back and forth, ending with both swap slots past the start.
    add_point(100, 0);
    add_point(50, 0);
    add_point(200, 0);
    add_point(10, 0);
    add_point(-300, 0);
    add_point(-300, 0);
    add_point(0, 7);
    add_point(32767, -1);
    drain_block();

    // Random sets under each idling pattern; the sender waits out every set
    // between patterns.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 70; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      queue_random_sets(7);
      drain_block();
    end

    // Let any stray output show up before the verdict.
    repeat (60) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/nfps_pkg.sv
rtl/nearest_farthest_point_swap.sv
test/nearest_farthest_point_swap_test.sv
